// File: hdl/anp_pkg.sv
// Package with the shared types, character codes and digit decoder of the ASCII number parser.
`timescale 1ns / 1ps
`default_nettype none

package anp_pkg;

    localparam int unsigned ValueWidth = 32;
    localparam int unsigned CountWidth = 16;
    localparam int unsigned CharWidth  = 8;

    localparam logic [CharWidth-1:0]  CHAR_ZERO    = 8'd48;
    localparam logic [CharWidth-1:0]  CHAR_NINE    = 8'd57;
    localparam logic [CharWidth-1:0]  CHAR_UPPER_A = 8'd65;
    localparam logic [CharWidth-1:0]  CHAR_UPPER_F = 8'd70;
    localparam logic [CharWidth-1:0]  CHAR_LOWER_A = 8'h61;
    localparam logic [CharWidth-1:0]  CHAR_LOWER_F = 8'h66;
    localparam logic [CharWidth-1:0]  CHAR_LOWER_X = 8'h78;
    localparam logic [CharWidth-1:0]  UPPER_OFFSET = 8'd55;
    localparam logic [CharWidth-1:0]  LOWER_OFFSET = 8'd87;
    localparam logic [CountWidth-1:0] COUNT_MAX    = 16'hFFFF;

    // Parser phase: idle, a lone leading zero seen, or accumulating digits.
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ZERO   = 2'd1,
        PH_DIGITS = 2'd2
    } phase_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } digit_t;

    // Decodes one character as a decimal digit, or as a hex digit when hex is set.
    function automatic digit_t digit_of(input logic [CharWidth-1:0] c, input logic hex);
        digit_t             d;
        logic [CharWidth-1:0] diff;
        d    = '0;
        diff = '0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            diff = c - CHAR_ZERO;
            d.ok = 1'b1;
        end else if (hex && c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
            diff = c - UPPER_OFFSET;
            d.ok = 1'b1;
        end else if (hex && c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
            diff = c - LOWER_OFFSET;
            d.ok = 1'b1;
        end
        d.val = diff[3:0];
        return d;
    endfunction

endpackage

`default_nettype wire

// File: hdl/ascii_number_parser_top.sv
// Top level of the streaming ASCII decimal/hex to unsigned integer parser.
//
//  Channel | Direction | tdata (low bit first)                     | tuser          | Per word
//  --------+-----------+-------------------------------------------+----------------+----------
//  s_      | in        | [7:0] ascii_char                          | [0] first_char | one char
//  m_      | out       | [31:0] number_value, [47:32] chars_consumed | [0] was_hex  | one number
//
// Each character word is captured in an input register and parsed, once the result slot is
// free, by the digit decoder and shift-and-add accumulator (total*10 or total*16 plus digit),
// which update the parser state and load the result register in a single pass.
// A new word is accepted every cycle unless an untaken result stalls the parse stage.
// Only the character that ends a number produces a result word; all others produce none.
// When the result register holds an untaken word, the input register holds its word and
// s_tready drops once both are full; nothing is lost or repeated.
// aresetn is synchronous and active low; it returns the parser to idle and empties both
// registers.
`timescale 1ns / 1ps
`default_nettype none

module ascii_number_parser_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ascii_char
    input  wire logic [0:0]  s_tuser,   // [0] first_char
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [31:0] number_value, [47:32] chars_consumed
    output logic [0:0]       m_tuser    // [0] was_hex
);

    import anp_pkg::*;

    // Input register.
    logic                 in_vld_reg, in_vld_next;
    logic [CharWidth-1:0] in_char_reg;
    logic                 in_first_reg;

    // Parser state.
    phase_t                phase_reg, phase_next;
    logic                  hex_reg, hex_next;
    logic [ValueWidth-1:0] total_reg, total_next;
    logic [CountWidth-1:0] count_reg, count_next;

    // Result register.
    logic                  out_vld_reg, out_vld_next;
    logic [ValueWidth-1:0] out_value_reg, out_value_next;
    logic [CountWidth-1:0] out_count_reg, out_count_next;
    logic                  out_hex_reg, out_hex_next;

    logic                  fire;
    logic                  has_result;
    logic                  use_hex;
    digit_t                dig;
    logic [ValueWidth-1:0] scaled;
    logic [ValueWidth-1:0] accum;
    logic [CountWidth-1:0] count_bump;

    // The parse stage advances whenever it holds a word and the result slot can take one.
    assign fire     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || fire;

    assign in_vld_next = (s_tvalid && s_tready) ? 1'b1 : (fire ? 1'b0 : in_vld_reg);

    // Hex digits are only legal once the prefix has switched the parser to hex.
    assign use_hex = !in_first_reg && (phase_reg == PH_DIGITS) && hex_reg;
    assign dig     = digit_of(in_char_reg, use_hex);

    // Multiply by 16 or by 10 (8x + 2x), then add the digit, all modulo 2^32.
    assign scaled = hex_reg ? {total_reg[ValueWidth-5:0], 4'b0000}
                            : ({total_reg[ValueWidth-4:0], 3'b000} +
                               {total_reg[ValueWidth-2:0], 1'b0});
    assign accum  = scaled + {{(ValueWidth-4){1'b0}}, dig.val};

    assign count_bump = (count_reg != COUNT_MAX) ? count_reg + 1'b1 : count_reg;

    // Next-state logic of the parser.
    always_comb begin
        phase_next = phase_reg;
        hex_next   = hex_reg;
        total_next = total_reg;
        count_next = count_reg;
        if (fire) begin
            if (in_first_reg) begin
                hex_next   = 1'b0;
                total_next = '0;
                count_next = '0;
                if (in_char_reg == CHAR_ZERO) begin
                    count_next = 16'd1;
                    phase_next = PH_ZERO;
                end else if (dig.ok) begin
                    total_next = {{(ValueWidth-4){1'b0}}, dig.val};
                    count_next = 16'd1;
                    phase_next = PH_DIGITS;
                end else begin
                    phase_next = PH_IDLE;
                end
            end else begin
                case (phase_reg)
                    PH_ZERO: begin
                        if (in_char_reg == CHAR_LOWER_X) begin
                            hex_next   = 1'b1;
                            count_next = 16'd2;
                            phase_next = PH_DIGITS;
                        end else if (dig.ok) begin
                            total_next = {{(ValueWidth-4){1'b0}}, dig.val};
                            count_next = count_bump;
                            phase_next = PH_DIGITS;
                        end else begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_DIGITS: begin
                        if (dig.ok) begin
                            total_next = accum;
                            count_next = count_bump;
                        end else begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // Result logic: the first rejected character of a number emits the number so far.
    always_comb begin
        has_result = 1'b0;
        if (in_first_reg) begin
            has_result = (in_char_reg != CHAR_ZERO) && !dig.ok;
        end else begin
            case (phase_reg)
                PH_ZERO:   has_result = (in_char_reg != CHAR_LOWER_X) && !dig.ok;
                PH_DIGITS: has_result = !dig.ok;
                default:   has_result = 1'b0;
            endcase
        end

        out_value_next = out_value_reg;
        out_count_next = out_count_reg;
        out_hex_next   = out_hex_reg;
        if (fire && has_result) begin
            out_value_next = in_first_reg ? '0   : total_reg;
            out_count_next = in_first_reg ? '0   : count_reg;
            out_hex_next   = in_first_reg ? 1'b0 : hex_reg;
        end

        if (fire) begin
            out_vld_next = has_result;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end else begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            phase_reg   <= PH_IDLE;
            hex_reg     <= 1'b0;
            total_reg   <= '0;
            count_reg   <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            phase_reg   <= phase_next;
            hex_reg     <= hex_next;
            total_reg   <= total_next;
            count_reg   <= count_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg  <= s_tdata;
            in_first_reg <= s_tuser[0];
        end
        out_value_reg <= out_value_next;
        out_count_reg <= out_count_next;
        out_hex_reg   <= out_hex_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_count_reg, out_value_reg};
    assign m_tuser  = out_hex_reg;

    // A hex result always counts at least the two prefix characters.
    a_hex_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[47:32] >= 16'd2))
        else $error("hex result with fewer than two consumed characters");

    // After a lone leading zero the total is zero, one character is counted, not hex.
    a_zero_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_ZERO) |-> (total_reg == '0 && count_reg == 16'd1 && !hex_reg))
        else $error("inconsistent state after a leading zero");

    // A word held in the input register stays there until the parse stage takes it.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !fire) |=> (in_vld_reg && $stable(in_char_reg)
                                   && $stable(in_first_reg)))
        else $error("input word dropped before parsing");

    // A result that has not been taken is not overwritten.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && !m_tready) |=> (out_vld_reg && $stable(out_value_reg)
                                        && $stable(out_count_reg)))
        else $error("untaken result overwritten");

endmodule

`default_nettype wire
